// ----- rtl/rgbled_pkg.sv -----
// Package: shared types and constants for the RGB LED blink/flash controller.
`timescale 1ns / 1ps
`default_nettype none
package rgbled_pkg;

	localparam int TIME_W  = 32;   // time arithmetic wraps modulo 2^TIME_W
	localparam int NOW_W   = 32;   // width of the now_ms port
	localparam int FLASH_W = 32;   // width of the flash_length_ms port
	localparam int LEVEL_W = 8;
	localparam int COUNT_W = 8;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_W-1:0] BLINK_ON_RST   = 16'd200;
	localparam logic [CFG_W-1:0] BLINK_WAIT_RST = 16'd300;
	localparam logic [CFG_W-1:0] COOLDOWN_RST   = 16'd2000;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_COLOUR = 3'd1,
		OP_FLASH  = 3'd2,
		OP_BLINK  = 3'd3,
		OP_OFF    = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLINK_ON   = 2'd0,
		REG_BLINK_WAIT = 2'd1,
		REG_COOLDOWN   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [TIME_W-1:0]  now;
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
		logic [FLASH_W-1:0] flash_len;
		logic [COUNT_W-1:0] count;
		logic               rep;
	} cmd_t;

	typedef struct packed {
		logic [CFG_W-1:0] on_ms;
		logic [CFG_W-1:0] wait_ms;
		logic [CFG_W-1:0] cool_ms;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
		logic               active;
	} drive_t;

endpackage
`default_nettype wire

// ----- rtl/rgbled_seq.sv -----
// Sequencer state and per-command next-state logic for the RGB LED controller.
`timescale 1ns / 1ps
`default_nettype none
module rgbled_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire rgbled_pkg::cmd_t    cmd,
	input  wire rgbled_pkg::cfg_t    cfg,
	output rgbled_pkg::drive_t       drive
);

	logic [rgbled_pkg::LEVEL_W-1:0] red_q, green_q, blue_q;
	logic                           running_q, lit_q, repeating_q;
	logic [rgbled_pkg::TIME_W-1:0]  start_q;
	logic [rgbled_pkg::FLASH_W-1:0] flash_q;
	logic [rgbled_pkg::COUNT_W-1:0] burst_q, left_q;

	logic [rgbled_pkg::LEVEL_W-1:0] red_d, green_d, blue_d;
	logic                           running_d, lit_d, repeating_d;
	logic [rgbled_pkg::TIME_W-1:0]  start_d;
	logic [rgbled_pkg::FLASH_W-1:0] flash_d;
	logic [rgbled_pkg::COUNT_W-1:0] burst_d, left_d;

	logic [rgbled_pkg::TIME_W-1:0]  delta, on_ext, wait_ext, cool_ext, past_on;
	logic [rgbled_pkg::TIME_W-1:0]  flash_ext;

	assign on_ext   = {{(rgbled_pkg::TIME_W-rgbled_pkg::CFG_W){1'b0}}, cfg.on_ms};
	assign wait_ext = {{(rgbled_pkg::TIME_W-rgbled_pkg::CFG_W){1'b0}}, cfg.wait_ms};
	assign cool_ext = {{(rgbled_pkg::TIME_W-rgbled_pkg::CFG_W){1'b0}}, cfg.cool_ms};
	assign flash_ext = flash_q[rgbled_pkg::TIME_W-1:0];
	assign delta    = cmd.now - start_q;
	assign past_on  = delta - on_ext;

	always_comb begin
		red_d       = red_q;
		green_d     = green_q;
		blue_d      = blue_q;
		running_d   = running_q;
		lit_d       = lit_q;
		repeating_d = repeating_q;
		start_d     = start_q;
		flash_d     = flash_q;
		burst_d     = burst_q;
		left_d      = left_q;
		case (cmd.op)
			rgbled_pkg::OP_TICK: begin
				if (running_q) begin
					if (left_q != '0) begin
						if (delta < on_ext) begin
							lit_d = 1'b1;
						end else begin
							lit_d = 1'b0;
							if (past_on > wait_ext) begin
								start_d = cmd.now;
								left_d  = left_q - rgbled_pkg::COUNT_W'(1);
								// last blink of a one-shot burst
								if (left_q == rgbled_pkg::COUNT_W'(1) && !repeating_q)
									running_d = 1'b0;
							end
						end
					end else if (burst_q != '0 && repeating_q) begin
						if (delta > cool_ext) begin
							start_d = cmd.now;
							left_d  = burst_q;
						end
					end else if (flash_q != '0 && delta >= flash_ext) begin
						running_d = 1'b0;
						lit_d     = 1'b0;
					end
				end
			end
			rgbled_pkg::OP_COLOUR: begin
				red_d   = cmd.red;
				green_d = cmd.green;
				blue_d  = cmd.blue;
				lit_d   = running_q;
			end
			rgbled_pkg::OP_FLASH: begin
				// a plain flash in progress ignores a new flash
				if (!(running_q && burst_q == '0)) begin
					running_d   = 1'b1;
					start_d     = cmd.now;
					flash_d     = cmd.flash_len;
					burst_d     = '0;
					left_d      = '0;
					repeating_d = 1'b0;
					lit_d       = 1'b1;
				end
			end
			rgbled_pkg::OP_BLINK: begin
				if (running_q && cmd.count == '0) begin
					running_d = 1'b0;
					lit_d     = 1'b0;
				end else if (running_q) begin
					repeating_d = cmd.rep;
					burst_d     = cmd.count;
					if (left_q > cmd.count)
						left_d = cmd.count;
				end else begin
					running_d   = 1'b1;
					start_d     = cmd.now;
					flash_d     = '0;
					burst_d     = cmd.count;
					left_d      = cmd.count;
					repeating_d = cmd.rep;
					lit_d       = 1'b1;
				end
			end
			rgbled_pkg::OP_OFF: begin
				running_d = 1'b0;
				lit_d     = 1'b0;
			end
			default: ;
		endcase
	end

	always_comb begin
		drive.red    = lit_d ? red_d   : '0;
		drive.green  = lit_d ? green_d : '0;
		drive.blue   = lit_d ? blue_d  : '0;
		drive.active = running_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q       <= '0;
			green_q     <= '0;
			blue_q      <= '0;
			running_q   <= 1'b0;
			lit_q       <= 1'b0;
			repeating_q <= 1'b0;
			start_q     <= '0;
			flash_q     <= '0;
			burst_q     <= '0;
			left_q      <= '0;
		end else if (adv) begin
			red_q       <= red_d;
			green_q     <= green_d;
			blue_q      <= blue_d;
			running_q   <= running_d;
			lit_q       <= lit_d;
			repeating_q <= repeating_d;
			start_q     <= start_d;
			flash_q     <= flash_d;
			burst_q     <= burst_d;
			left_q      <= left_d;
		end
	end

`ifndef SYNTHESIS
	a_lit_needs_running: assert property (@(posedge clk) disable iff (!arst_n)
		lit_q |-> running_q)
		else $error("LED lit while sequencer idle");

	a_left_within_burst: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= burst_q)
		else $error("blinks left exceeds burst size");

	a_off_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd.op == rgbled_pkg::OP_OFF) |=> (!running_q && !lit_q))
		else $error("turn off left sequencer running");
`endif

endmodule
`default_nettype wire

// ----- rtl/rgb_led_blink_flash_controller.sv -----
// Top level: handshakes, config registers, input and result registers.
`timescale 1ns / 1ps
`default_nettype none
// RGB LED blink/flash controller. Each input beat carries one command (tick, set
// colour, flash, blink, off) plus the current millisecond time, and yields exactly
// one result beat with the three drive levels and the active flag as they stand
// after the command. One beat per clock is sustained while out_ready is high; each
// beat passes the input register, then the state update that loads the result
// register. A full result register with out_ready low stalls the input side.
// Time differences are computed modulo 2^32. Configuration registers (blink on
// time, blink wait, burst cool-down, all 16-bit ms) accept writes every cycle and
// should be changed only while the block is idle.
module rgb_led_blink_flash_controller (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [2:0]                            operation,
	input  wire logic [rgbled_pkg::NOW_W-1:0]          now_ms,
	input  wire logic [rgbled_pkg::LEVEL_W-1:0]        red,
	input  wire logic [rgbled_pkg::LEVEL_W-1:0]        green,
	input  wire logic [rgbled_pkg::LEVEL_W-1:0]        blue,
	input  wire logic [rgbled_pkg::FLASH_W-1:0]        flash_length_ms,
	input  wire logic [rgbled_pkg::COUNT_W-1:0]        blink_number,
	input  wire logic                                  repeat_bursts,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [rgbled_pkg::LEVEL_W-1:0]             red_drive,
	output logic [rgbled_pkg::LEVEL_W-1:0]             green_drive,
	output logic [rgbled_pkg::LEVEL_W-1:0]             blue_drive,
	output logic                                       is_active,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [rgbled_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rgbled_pkg::CFG_W-1:0]          cfg_data
);

	rgbled_pkg::cfg_t   cfg_q;
	rgbled_pkg::cmd_t   cmd_s1;
	logic               valid_s1;
	rgbled_pkg::drive_t drive_q;
	rgbled_pkg::drive_t drive;
	logic               out_valid_q;
	logic               adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_ms   <= rgbled_pkg::BLINK_ON_RST;
			cfg_q.wait_ms <= rgbled_pkg::BLINK_WAIT_RST;
			cfg_q.cool_ms <= rgbled_pkg::COOLDOWN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rgbled_pkg::REG_BLINK_ON:   cfg_q.on_ms   <= cfg_data;
				rgbled_pkg::REG_BLINK_WAIT: cfg_q.wait_ms <= cfg_data;
				rgbled_pkg::REG_COOLDOWN:   cfg_q.cool_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 moves on when the result register is free or being drained
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1.op        <= operation;
			cmd_s1.now       <= now_ms[rgbled_pkg::TIME_W-1:0];
			cmd_s1.red       <= red;
			cmd_s1.green     <= green;
			cmd_s1.blue      <= blue;
			cmd_s1.flash_len <= flash_length_ms;
			cmd_s1.count     <= blink_number;
			cmd_s1.rep       <= repeat_bursts;
		end
	end

	rgbled_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cmd    (cmd_s1),
		.cfg    (cfg_q),
		.drive  (drive)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			drive_q <= drive;
	end

	assign out_valid   = out_valid_q;
	assign red_drive   = drive_q.red;
	assign green_drive = drive_q.green;
	assign blue_drive  = drive_q.blue;
	assign is_active   = drive_q.active;

`ifndef SYNTHESIS
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("stalled beat dropped from stage 1");

	a_result_follows_adv: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("processed beat produced no result");
`endif

endmodule
`default_nettype wire
